[hdl/csism_pkg.sv]
`default_nettype none
package csism_pkg;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2,
      CSR_FOLD_CASE      = 2'd3
   } csr_index_type;

   localparam int unsigned CSR_INDEX_BITS  = 2;
   localparam int unsigned CSR_DATA_BITS   = 64;
   localparam int unsigned LENGTH_BITS     = 5;
   localparam int unsigned BYTE_BITS       = 8;
   localparam int unsigned START_BITS      = 16;
   localparam int unsigned RSP_DATA_BITS   = 24;
   localparam int unsigned BYTES_PER_WORD  = 8;
   localparam int unsigned PATTERN_BYTES   = 16;

   // ASCII lower-case letters
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // controls shared by every cell of the row
   typedef struct packed {
      logic advance;    // an item is accepted this cycle
      logic restart;    // accepted item closes the text
      logic fold_case;  // fold a-z to upper case
   } cell_ctrl_type;

   // per-item view handed to the match tracker
   typedef struct packed {
      logic advance;
      logic last;
      logic tap;        // updated progress bit at the final pattern position
   } track_step_type;

   // one result item, field order as in rsp_tdata
   typedef struct packed {
      logic                  position_overflow;
      logic [START_BITS-1:0] match_start;
      logic                  found;
   } result_type;

   // fold an ASCII letter to upper case when enabled
   function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
      logic [7:0] r;
      r = b;
      if (en && (b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z)) begin
         r = b - CASE_OFFSET;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/csism_cell.sv]
`default_nettype none
// One pattern position: compares its pattern byte against the incoming
// text byte and extends the partial match handed on by its left neighbor.
module csism_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire csism_pkg::cell_ctrl_type ctrl,
   input  wire logic [7:0]              text_folded,
   input  wire logic [7:0]              pattern_byte,
   input  wire logic                    prev_bit,
   output logic                         step_bit,
   output logic                         progress_ff
);

   logic hit;
   logic progress_in;

   // byte compare and chain extension
   assign hit      = (csism_pkg::fold_byte(pattern_byte, ctrl.fold_case) == text_folded);
   assign step_bit = prev_bit & hit;

   // progress is cleared once the text ends
   always_comb begin
      progress_in = progress_ff;
      if (ctrl.advance) begin
         progress_in = ctrl.restart ? 1'b0 : step_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         progress_ff <= 1'b0;
      end else begin
         progress_ff <= progress_in;
      end
   end

endmodule
`default_nettype wire

[hdl/csism_tracker.sv]
`default_nettype none
// Byte position counter, earliest match start and overflow flag; forms the
// result for the byte that closes the text.
module csism_tracker #(
   parameter int unsigned POSITION_BITS = 16,
   parameter int unsigned LEN_W         = 5
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire csism_pkg::track_step_type step,
   input  wire logic [LEN_W-1:0]          len,
   output csism_pkg::result_type          result
);

   localparam int unsigned SW = (POSITION_BITS > csism_pkg::START_BITS) ?
                                POSITION_BITS : csism_pkg::START_BITS;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic                     found_ff, found_in;
   logic                     ovf_ff, ovf_in;

   logic                     at_max;
   logic                     hit;
   logic [POSITION_BITS-1:0] len_m1;
   logic [POSITION_BITS-1:0] start_next;
   logic                     found_next;
   logic                     ovf_next;
   logic [SW-1:0]            start_ext;

   assign at_max     = (pos_ff == {POSITION_BITS{1'b1}});
   assign len_m1     = POSITION_BITS'(len) - POSITION_BITS'(1);
   // first full occurrence on a byte inside the position range
   assign hit        = (len != '0) && !at_max && !found_ff && step.tap && (pos_ff >= len_m1);
   assign found_next = found_ff | hit;
   assign start_next = hit ? (pos_ff - len_m1) : start_ff;
   assign ovf_next   = ovf_ff | at_max;
   assign start_ext  = SW'(start_next);

   // state update, cleared after the closing byte
   always_comb begin
      pos_in   = pos_ff;
      start_in = start_ff;
      found_in = found_ff;
      ovf_in   = ovf_ff;
      if (step.advance) begin
         if (step.last) begin
            pos_in   = '0;
            start_in = '0;
            found_in = 1'b0;
            ovf_in   = 1'b0;
         end else begin
            pos_in   = at_max ? pos_ff : (pos_ff + POSITION_BITS'(1));
            start_in = start_next;
            found_in = found_next;
            ovf_in   = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         start_ff <= '0;
         found_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         start_ff <= start_in;
         found_ff <= found_in;
         ovf_ff   <= ovf_in;
      end
   end

   // result; an empty pattern always matches at the start
   always_comb begin
      result.position_overflow = ovf_next;
      if (len == '0) begin
         result.found       = 1'b1;
         result.match_start = '0;
      end else begin
         result.found       = found_next;
         result.match_start = found_next ? start_ext[csism_pkg::START_BITS-1:0] : '0;
      end
   end

endmodule
`default_nettype wire

[hdl/case_insensitive_substring_match_core.sv]
`default_nettype none
// Substring search over a byte stream, with optional ASCII case folding.
//
// req_*: one text byte per item in req_tdata[7:0]; req_tlast marks the final
//   byte of a text. rsp_*: one result item per text, sent after its last
//   byte: found, start index of the first occurrence, position overflow.
// csr_*: write-only registers (pattern low/high words, length, fold_case);
//   the user must write them only while no text is in flight; the block does not enforce this.
// Throughput: one byte per cycle while req_tready is high. Each pattern position is one cell of a
//   row that shifts the partial-match bit one position per byte, so the
//   rate does not depend on pattern length.
// Output: the result is registered and appears on rsp_tvalid the cycle after the last byte is
//   accepted, unless an earlier result is still held; it then waits in the skid register.
// Stall: a result register plus a one-entry skid register; req_tready drops
//   only when both hold results that the receiver has not taken.
// Reset: synchronous; clears stream state and the output valid flags, restores
//   the registers to empty pattern with case folding on.
module case_insensitive_substring_match_core #(
   parameter int unsigned PATTERN_MAX   = 16,
   parameter int unsigned POSITION_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // text_byte [7:0]
   input  wire logic [7:0]                         req_tdata,
   input  wire logic                               req_tlast,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // found [0], match_start [16:1], position_overflow [17], zero [23:18]
   output logic [csism_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_wr_en,
   input  wire logic [csism_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [csism_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int unsigned CMP_W = (LEN_W > csism_pkg::LENGTH_BITS) ?
                                   LEN_W : csism_pkg::LENGTH_BITS;
   localparam int unsigned TAP_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   // configuration registers
   logic [csism_pkg::CSR_DATA_BITS-1:0] pattern_low_ff, pattern_high_ff;
   logic [csism_pkg::LENGTH_BITS-1:0]   pattern_length_ff;
   logic                                fold_case_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
         fold_case_ff      <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csism_pkg::csr_index_type'(csr_index))
            csism_pkg::CSR_PATTERN_LOW:    pattern_low_ff    <= csr_wdata;
            csism_pkg::CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_wdata;
            csism_pkg::CSR_PATTERN_LENGTH:
               pattern_length_ff <= csr_wdata[csism_pkg::LENGTH_BITS-1:0];
            csism_pkg::CSR_FOLD_CASE:      fold_case_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective length, clamped to the row size
   logic [LEN_W-1:0] len;
   assign len = (CMP_W'(pattern_length_ff) > CMP_W'(PATTERN_MAX)) ?
                LEN_W'(PATTERN_MAX) : LEN_W'(pattern_length_ff);

   // input handshake
   logic                    skid_valid_ff, skid_valid_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    accept;
   logic [7:0]              text_folded;
   csism_pkg::cell_ctrl_type ctrl;

   assign req_tready  = !skid_valid_ff;
   assign accept      = req_tvalid && req_tready;
   assign text_folded = csism_pkg::fold_byte(req_tdata, fold_case_ff);

   assign ctrl.advance   = accept;
   assign ctrl.restart   = req_tlast;
   assign ctrl.fold_case = fold_case_ff;

   // row of match cells
   logic [PATTERN_MAX-1:0] step_bits;
   logic [PATTERN_MAX-1:0] progress;

   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      logic [7:0] pbyte;
      logic       prev;

      if (i < csism_pkg::BYTES_PER_WORD) begin : g_lo
         assign pbyte = pattern_low_ff[8*i +: 8];
      end else if (i < csism_pkg::PATTERN_BYTES) begin : g_hi
         assign pbyte = pattern_high_ff[8*(i-csism_pkg::BYTES_PER_WORD) +: 8];
      end else begin : g_zero
         assign pbyte = 8'h00;
      end

      if (i == 0) begin : g_head
         assign prev = 1'b1;
      end else begin : g_link
         assign prev = progress[i-1];
      end

      csism_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .text_folded  (text_folded),
         .pattern_byte (pbyte),
         .prev_bit     (prev),
         .step_bit     (step_bits[i]),
         .progress_ff  (progress[i])
      );
   end

   // updated progress at the final pattern position
   logic [TAP_W-1:0]          tap_idx;
   csism_pkg::track_step_type step;
   csism_pkg::result_type     result;

   assign tap_idx      = TAP_W'(len - LEN_W'(1));
   assign step.advance = accept;
   assign step.last    = req_tlast;
   assign step.tap     = (len != '0) && step_bits[tap_idx];

   csism_tracker #(
      .POSITION_BITS (POSITION_BITS),
      .LEN_W         (LEN_W)
   ) u_tracker (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .len    (len),
      .result (result)
   );

   // result register with skid entry
   csism_pkg::result_type out_ff, out_in, skid_ff, skid_in;
   logic                  push, take;

   assign push = accept && req_tlast;
   assign take = out_valid_ff && rsp_tready;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = csism_pkg::RSP_DATA_BITS'(out_ff);

   // skid entry only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full while result register empty");

   // closing byte is always followed by rsp_tvalid high in the next cycle
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> rsp_tvalid)
      else $error("no result after closing byte");

   // a nonzero start index only comes with a match
   a_start_needs_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[16:1] != 16'd0)) |-> rsp_tdata[0])
      else $error("match start without found");

endmodule
`default_nettype wire

[tb/sv/case_insensitive_substring_match_core_tb.sv]
module case_insensitive_substring_match_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 8;

   logic                                 clock;
   logic                                 reset;
   logic [7:0]                           req_tdata;
   logic                                 req_tlast;
   logic                                 req_tvalid;
   logic                                 req_tready;
   logic [csism_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready;
   logic                                 csr_wr_en;
   logic [csism_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [csism_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   case_insensitive_substring_match_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // shadow copy of the registers
   logic [63:0] cfg_pattern_low;
   logic [63:0] cfg_pattern_high;
   logic [4:0]  cfg_pattern_len;
   logic        cfg_fold;

   // search state mirrored per text
   logic [15:0] match_progress;
   logic [15:0] text_position;
   logic        hit_seen;
   logic [15:0] hit_start;
   logic        saturated_seen;

   csism_pkg::result_type expected_results[$];
   int          mismatch_count;
   int          cycle_count;
   bit          idling_on;
   int          stall_left;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("case_insensitive_substring_match_core test failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   function automatic logic [7:0] fold_char(input logic [7:0] c);
      if (cfg_fold && c >= "a" && c <= "z") return c - 8'h20;
      return c;
   endfunction

   function automatic logic [7:0] pattern_at(input int i);
      if (i < 8) return cfg_pattern_low[8*i +: 8];
      if (i < 16) return cfg_pattern_high[8*(i-8) +: 8];
      return 8'h00;
   endfunction

   function automatic int effective_len();
      return (cfg_pattern_len > csism_pkg::PATTERN_BYTES) ? csism_pkg::PATTERN_BYTES
                                                          : int'(cfg_pattern_len);
   endfunction

   // advance the search by one accepted byte, queue a result on the last one
   task automatic predict_byte(input logic [7:0] text_byte, input bit is_last);
      logic [7:0]  c;
      logic [15:0] hits;
      logic [15:0] idx;
      int          len;
      bit          in_range;
      csism_pkg::result_type r;
      c = fold_char(text_byte);
      len = effective_len();
      hits = '0;
      for (int i = 0; i < csism_pkg::PATTERN_BYTES; i++)
         if (fold_char(pattern_at(i)) == c) hits[i] = 1'b1;
      match_progress = ((match_progress << 1) | 16'h0001) & hits;
      idx = text_position;
      if (text_position == 16'hFFFF) begin
         saturated_seen = 1'b1;
         in_range = 1'b0;
      end else begin
         text_position++;
         in_range = 1'b1;
      end
      if (len > 0 && in_range && !hit_seen && match_progress[len-1] && int'(idx) >= len - 1)
      begin
         hit_seen = 1'b1;
         hit_start = idx - 16'(len - 1);
      end
      if (is_last) begin
         r.found = (len == 0) ? 1'b1 : hit_seen;
         r.match_start = (len == 0 || !hit_seen) ? 16'h0000 : hit_start;
         r.position_overflow = saturated_seen;
         expected_results.push_back(r);
         match_progress = '0;
         text_position = '0;
         hit_seen = 1'b0;
         hit_start = '0;
         saturated_seen = 1'b0;
      end
   endtask

   // send one text byte; returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] text_byte, input bit is_last);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = text_byte;
      req_tlast = is_last;
      do @(posedge clock); while (!req_tready);
      predict_byte(text_byte, is_last);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   // hold off until every result is in, then let the pipeline settle
   task automatic wait_results_done();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csism_pkg::csr_index_type idx, input logic [63:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         csism_pkg::CSR_PATTERN_LOW:    cfg_pattern_low = value;
         csism_pkg::CSR_PATTERN_HIGH:   cfg_pattern_high = value;
         csism_pkg::CSR_PATTERN_LENGTH: cfg_pattern_len = value[4:0];
         csism_pkg::CSR_FOLD_CASE:      cfg_fold = value[0];
         default: ;
      endcase
   endtask

   task automatic set_pattern(input logic [127:0] bytes, input logic [4:0] len, input bit fold);
      wait_results_done();
      write_csr(csism_pkg::CSR_PATTERN_LOW, bytes[63:0]);
      write_csr(csism_pkg::CSR_PATTERN_HIGH, bytes[127:64]);
      write_csr(csism_pkg::CSR_PATTERN_LENGTH, 64'(len));
      write_csr(csism_pkg::CSR_FOLD_CASE, 64'(fold));
   endtask

   function automatic logic [127:0] pack_text(input string s);
      logic [127:0] p;
      p = '0;
      for (int i = 0; i < s.len() && i < 16; i++) p[8*i +: 8] = s[i];
      return p;
   endfunction

   // result checker
   always @(posedge clock) begin
      csism_pkg::result_type got;
      csism_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = csism_pkg::result_type'(rsp_tdata[17:0]);
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with none pending, data %h", rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            if (got.found !== want.found)
               report_mismatch($sformatf("found %b, want %b", got.found, want.found));
            if (got.match_start !== want.match_start)
               report_mismatch($sformatf("match_start %0d, want %0d",
                                         got.match_start, want.match_start));
            if (got.position_overflow !== want.position_overflow)
               report_mismatch($sformatf("position_overflow %b, want %b",
                                         got.position_overflow, want.position_overflow));
            if (rsp_tdata[23:18] !== 6'b0)
               report_mismatch($sformatf("pad bits %b, want zero", rsp_tdata[23:18]));
         end
      end
   end

   // receiver stalls in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // registers at reset: empty pattern matches at position 0
   task automatic test_reset_defaults();
      send_text("a");
      send_text("Zq");
   endtask

   // folding on and off, non-letter neighbors of the letter ranges, overlap
   task automatic test_case_folding();
      set_pattern(pack_text("aB"), 5'd2, 1'b1);
      send_text("xAb");
      set_pattern(pack_text("aB"), 5'd2, 1'b0);
      send_text("ABaB");
      set_pattern(pack_text("`{"), 5'd2, 1'b1);
      send_text("@[`{");
      set_pattern(pack_text("aab"), 5'd3, 1'b1);
      send_text("AaAB");
   endtask

   // full-width pattern with extreme byte values, length above the maximum
   task automatic test_pattern_extremes();
      logic [127:0] p;
      p = pack_text("ABCDEFGHIJKLMNOP");
      p[7:0] = 8'h01;
      p[127:120] = 8'hFF;
      set_pattern(p, 5'd16, 1'b1);
      for (int i = 0; i < 16; i++) send_byte(p[8*i +: 8], i == 15);
      // clipped to 16 positions, the zero bytes beyond "AB" never match
      set_pattern(pack_text("AB"), 5'd31, 1'b0);
      send_text("AB");
   endtask

   // occurrence on the last in-range byte, then one on the saturated byte
   task automatic test_position_overflow();
      int n;
      logic [7:0] b;
      idling_on = 1'b0;
      set_pattern(pack_text("QZ"), 5'd2, 1'b0);
      n = 65535;
      for (int k = 0; k < n; k++) begin
         b = (k == n - 2) ? "Q" : (k == n - 1) ? "Z" : "a";
         send_byte(b, k == n - 1);
      end
      n = 65537;
      for (int k = 0; k < n; k++) begin
         b = (k == 65534) ? "Q" : (k == 65535) ? "Z" : "a";
         send_byte(b, k == n - 1);
      end
      wait_results_done();
      idling_on = 1'b1;
   endtask

   function automatic logic [7:0] flip_case(input logic [7:0] c);
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return c ^ 8'h20;
      return c;
   endfunction

   function automatic logic [7:0] pick_text_byte();
      string alphabet;
      logic [7:0] c;
      alphabet = "aAbBzZ@`{[";
      case ($urandom_range(0, 7))
         0:       c = 8'($urandom_range(1, 255));
         1, 2:    c = alphabet[$urandom_range(0, alphabet.len() - 1)];
         default: c = pattern_at($urandom_range(0, effective_len() > 0 ? effective_len() - 1 : 0));
      endcase
      if ($urandom_range(0, 1)) c = flip_case(c);
      if (c == 8'h00) c = 8'h01;
      return c;
   endfunction

   // random patterns and texts, mostly with planted occurrences
   task automatic test_random_texts();
      string alphabet;
      logic [127:0] p;
      logic [4:0] len;
      logic [7:0] text[$];
      logic [7:0] c;
      int tlen;
      int elen;
      int offset;
      int sent;
      alphabet = "aAbBzZ@`{[";
      for (int phase = 0; phase < 10; phase++) begin
         for (int i = 0; i < 16; i++)
            p[8*i +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                       : alphabet[$urandom_range(0, 9)];
         case (phase)
            0: len = 5'd0;
            1: len = 5'd16;
            2: len = 5'd31;
            default:
               case ($urandom_range(0, 9))
                  0:       len = 5'd0;
                  1:       len = 5'd16;
                  2:       len = 5'($urandom_range(17, 31));
                  default: len = 5'($urandom_range(1, 5));
               endcase
         endcase
         if (phase >= 8) idling_on = 1'b0;
         set_pattern(p, len, phase == 0 ? 1'b0 : 1'($urandom_range(0, 1)));
         elen = effective_len();
         sent = 0;
         while (sent < 40) begin
            tlen = (elen > 8 && $urandom_range(0, 1)) ? $urandom_range(elen, elen + 8)
                                                       : $urandom_range(1, 20);
            text.delete();
            for (int k = 0; k < tlen; k++) text.push_back(pick_text_byte());
            if (elen > 0 && elen <= tlen && $urandom_range(0, 3) != 0) begin
               offset = $urandom_range(0, tlen - elen);
               for (int k = 0; k < elen; k++) begin
                  c = pattern_at(k);
                  if (cfg_fold && $urandom_range(0, 1)) c = flip_case(c);
                  if (c == 8'h00) c = 8'h01;
                  text[offset + k] = c;
               end
            end
            for (int k = 0; k < tlen; k++) send_byte(text[k], k == tlen - 1);
            sent += tlen;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = csism_pkg::CSR_PATTERN_LOW;
      csr_wdata = '0;
      cfg_pattern_low = '0;
      cfg_pattern_high = '0;
      cfg_pattern_len = '0;
      cfg_fold = 1'b1;
      match_progress = '0;
      text_position = '0;
      hit_seen = 1'b0;
      hit_start = '0;
      saturated_seen = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      stall_left = 0;
      idling_on = 1'b1;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_case_folding();
      test_pattern_extremes();
      test_position_overflow();
      test_random_texts();

      while (expected_results.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("case_insensitive_substring_match_core test passed");
      end else begin
         $display("case_insensitive_substring_match_core test failed");
      end
      $finish;
   end

endmodule
